[rtl/core/nfqs_pkg.sv]
// Shared constants, codes and controller/datapath types for the fftshift reorder core.
`default_nettype none

package nfqs_pkg;

    // Defaults for the top-level parameters.
    localparam int STORE_DEPTH_DEF  = 4096;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Largest dimension count the core honours; higher settings are clamped to it.
    localparam int MAX_DIMENSIONS = 3;

    // Fixed field widths.
    localparam int DIMS        = 3;
    localparam int COUNT_W     = 2;
    localparam int SIZE_W      = 13;
    localparam int PART_W      = 2 * SIZE_W;
    localparam int TOTAL_W     = 3 * SIZE_W;
    localparam int PORT_W      = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DIMENSION_COUNT = 2'd0,
        REG_SIZE_DIM0       = 2'd1,
        REG_SIZE_DIM1       = 2'd2,
        REG_SIZE_DIM2       = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_EMIT = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic cfg_write;
        logic load_write;
        logic emit_start;
        logic error_load;
        logic result_load;
    } nfqs_cmd_t;

    typedef struct packed {
        logic size_error;
    } nfqs_status_t;

endpackage

`default_nettype wire

[rtl/core/nfqs_if.sv]
// Valid/ready channel interfaces for items, results and configuration writes.
`default_nettype none

interface nfqs_item_if;
    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic signed [nfqs_pkg::PORT_W-1:0] in_real;
    logic signed [nfqs_pkg::PORT_W-1:0] in_imag;

    modport source (output valid, output kind, output in_real, output in_imag, input ready);
    modport sink   (input valid, input kind, input in_real, input in_imag, output ready);
endinterface

interface nfqs_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [nfqs_pkg::PORT_W-1:0] out_real;
    logic signed [nfqs_pkg::PORT_W-1:0] out_imag;
    logic                               frame_last;
    logic                               size_error;

    modport source (output valid, output out_real, output out_imag, output frame_last,
                    output size_error, input ready);
    modport sink   (input valid, input out_real, input out_imag, input frame_last,
                    input size_error, output ready);
endinterface

interface nfqs_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [nfqs_pkg::CFG_INDEX_W-1:0]    index;
    logic [nfqs_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/nfqs_datapath.sv]
// Datapath: configuration registers, frame size, sample store, address arithmetic, result register.
`default_nettype none

module nfqs_datapath #(
    parameter int STORE_DEPTH  = nfqs_pkg::STORE_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = nfqs_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire nfqs_pkg::nfqs_cmd_t                cmd,
    output nfqs_pkg::nfqs_status_t                  status,
    input  wire logic [nfqs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [nfqs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic signed [nfqs_pkg::PORT_W-1:0] in_real,
    input  wire logic signed [nfqs_pkg::PORT_W-1:0] in_imag,
    output logic signed [nfqs_pkg::PORT_W-1:0]      out_real,
    output logic signed [nfqs_pkg::PORT_W-1:0]      out_imag,
    output logic                                    frame_last,
    output logic                                    size_error
);

    localparam int AW      = $clog2(STORE_DEPTH);
    localparam int SW      = SAMPLE_WIDTH;
    localparam int DIMS    = nfqs_pkg::DIMS;
    localparam int SIZE_W  = nfqs_pkg::SIZE_W;
    localparam int PART_W  = nfqs_pkg::PART_W;
    localparam int TOTAL_W = nfqs_pkg::TOTAL_W;
    localparam int COUNT_W = nfqs_pkg::COUNT_W;
    localparam int PORT_W  = nfqs_pkg::PORT_W;

    // Configuration registers.
    logic [COUNT_W-1:0] dimension_count_reg;
    logic [SIZE_W-1:0]  size_dim0_reg;
    logic [SIZE_W-1:0]  size_dim1_reg;
    logic [SIZE_W-1:0]  size_dim2_reg;

    // Effective lengths, slowest first, and the frame size.
    logic [SIZE_W-1:0]  n_next [DIMS];
    logic [SIZE_W-1:0]  n_reg  [DIMS];
    logic [PART_W-1:0]  prod01_reg;
    logic [TOTAL_W-1:0] total_reg;

    // Load and emit positions.
    logic [AW-1:0]      pos_reg;
    logic [AW-1:0]      pos_next;
    logic [AW-1:0]      load_addr;
    logic [SIZE_W-1:0]  coord_reg  [DIMS];
    logic [SIZE_W-1:0]  coord_next [DIMS];

    // Address pipeline.
    logic [SIZE_W-1:0]  s_next [DIMS];
    logic [SIZE_W-1:0]  s_reg  [DIMS];
    logic               last_next;
    logic               last_reg;
    logic [PART_W-1:0]  part_reg;
    logic [TOTAL_W-1:0] addr_full;
    logic [AW-1:0]      addr_reg;

    // Sample store and result register.
    logic [2*SW-1:0]    mem [STORE_DEPTH];
    logic [2*SW-1:0]    rd_data_reg;
    logic signed [SW-1:0] rd_real;
    logic signed [SW-1:0] rd_imag;
    logic signed [PORT_W-1:0] out_real_reg;
    logic signed [PORT_W-1:0] out_imag_reg;
    logic               frame_last_reg;
    logic               size_error_reg;
    logic               err;

    // Map the dimension count onto the three slots: the last used dimension is fastest.
    always_comb
    begin
        logic [COUNT_W-1:0] cnt;
        logic [SIZE_W-1:0]  raw [DIMS];
        cnt = dimension_count_reg;
        if (cnt == '0)
            cnt = COUNT_W'(1);
        if (cnt > COUNT_W'(nfqs_pkg::MAX_DIMENSIONS))
            cnt = COUNT_W'(nfqs_pkg::MAX_DIMENSIONS);
        raw[0] = SIZE_W'(1);
        raw[1] = SIZE_W'(1);
        raw[2] = SIZE_W'(1);
        if (cnt == COUNT_W'(1))
        begin
            raw[2] = size_dim0_reg;
        end
        else if (cnt == COUNT_W'(2))
        begin
            raw[1] = size_dim0_reg;
            raw[2] = size_dim1_reg;
        end
        else
        begin
            raw[0] = size_dim0_reg;
            raw[1] = size_dim1_reg;
            raw[2] = size_dim2_reg;
        end
        for (int i = 0; i < DIMS; i++)
            n_next[i] = (raw[i] == '0) ? SIZE_W'(1) : raw[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_count_reg <= COUNT_W'(1);
            size_dim0_reg       <= SIZE_W'(1);
            size_dim1_reg       <= SIZE_W'(1);
            size_dim2_reg       <= SIZE_W'(1);
        end
        else if (cmd.cfg_write)
        begin
            unique case (nfqs_pkg::cfg_reg_t'(cfg_index))
                nfqs_pkg::REG_DIMENSION_COUNT: dimension_count_reg <= cfg_data[COUNT_W-1:0];
                nfqs_pkg::REG_SIZE_DIM0:       size_dim0_reg       <= cfg_data[SIZE_W-1:0];
                nfqs_pkg::REG_SIZE_DIM1:       size_dim1_reg       <= cfg_data[SIZE_W-1:0];
                nfqs_pkg::REG_SIZE_DIM2:       size_dim2_reg       <= cfg_data[SIZE_W-1:0];
            endcase
        end
    end

    // Frame size is registered through n_reg, prod01_reg and total_reg after the configuration registers.
    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        prod01_reg <= PART_W'(n_reg[0]) * PART_W'(n_reg[1]);
        total_reg  <= TOTAL_W'(prod01_reg) * TOTAL_W'(n_reg[2]);
    end

    assign err               = total_reg > TOTAL_W'(STORE_DEPTH);
    assign status.size_error = err;

    // Load position, with a stale position from an earlier frame size treated as zero.
    always_comb
    begin
        logic [AW:0] inc;
        load_addr = (TOTAL_W'(pos_reg) >= total_reg) ? '0 : pos_reg;
        inc       = {1'b0, load_addr} + (AW+1)'(1);
        pos_next  = (TOTAL_W'(inc) >= total_reg) ? '0 : inc[AW-1:0];
    end

    // Source coordinates and the odometer step, fastest dimension first.
    always_comb
    begin
        logic [SIZE_W-1:0] c_fix [DIMS];
        logic [SIZE_W:0]   sum;
        logic [SIZE_W:0]   inc;
        logic              carry;
        last_next = 1'b1;
        for (int i = 0; i < DIMS; i++)
        begin
            c_fix[i]  = (coord_reg[i] >= n_reg[i]) ? '0 : coord_reg[i];
            sum       = {1'b0, c_fix[i]} + {2'b00, n_reg[i][SIZE_W-1:1]};
            s_next[i] = (sum >= {1'b0, n_reg[i]}) ? SIZE_W'(sum - {1'b0, n_reg[i]})
                                                  : sum[SIZE_W-1:0];
            if (c_fix[i] != n_reg[i] - SIZE_W'(1))
                last_next = 1'b0;
        end
        carry = 1'b1;
        for (int i = DIMS - 1; i >= 0; i--)
        begin
            inc = {1'b0, c_fix[i]} + (SIZE_W+1)'(1);
            if (!carry)
                coord_next[i] = c_fix[i];
            else if (inc >= {1'b0, n_reg[i]})
                coord_next[i] = '0;
            else
            begin
                coord_next[i] = inc[SIZE_W-1:0];
                carry         = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int i = 0; i < DIMS; i++)
                coord_reg[i] <= '0;
        end
        else
        begin
            if (cmd.load_write)
                pos_reg <= pos_next;
            if (cmd.emit_start)
                coord_reg <= coord_next;
        end
    end

    // Linear source address over two multiply steps.
    assign addr_full = TOTAL_W'(part_reg) * TOTAL_W'(n_reg[2]) + TOTAL_W'(s_reg[2]);

    always_ff @(posedge clk)
    begin
        if (cmd.emit_start)
        begin
            s_reg    <= s_next;
            last_reg <= last_next;
        end
        part_reg <= PART_W'(s_reg[0]) * PART_W'(n_reg[1]) + PART_W'(s_reg[1]);
        addr_reg <= addr_full[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_write)
            mem[load_addr] <= {in_imag[SW-1:0], in_real[SW-1:0]};
        rd_data_reg <= mem[addr_reg];
    end

    assign rd_real = rd_data_reg[SW-1:0];
    assign rd_imag = rd_data_reg[2*SW-1:SW];

    always_ff @(posedge clk)
    begin
        if (cmd.error_load)
        begin
            out_real_reg   <= '0;
            out_imag_reg   <= '0;
            frame_last_reg <= 1'b0;
            size_error_reg <= 1'b1;
        end
        else if (cmd.result_load)
        begin
            out_real_reg   <= PORT_W'(rd_real);
            out_imag_reg   <= PORT_W'(rd_imag);
            frame_last_reg <= last_reg;
            size_error_reg <= 1'b0;
        end
    end

    assign out_real   = out_real_reg;
    assign out_imag   = out_imag_reg;
    assign frame_last = frame_last_reg;
    assign size_error = size_error_reg;

`ifndef SYNTHESIS
    a_load_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_write |=> (TOTAL_W'(pos_reg) < total_reg))
        else $error("load position left the frame after a load");

    a_coords_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_start |=> (coord_reg[0] < n_reg[0] && coord_reg[1] < n_reg[1]
                            && coord_reg[2] < n_reg[2]))
        else $error("emit coordinates left the frame after a step");

    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.error_load |=> (size_error_reg && !frame_last_reg && out_real_reg == '0
                            && out_imag_reg == '0))
        else $error("size error result carries a non-zero payload");
`endif

endmodule

`default_nettype wire

[rtl/core/nfqs_ctrl.sv]
// Controller: handshakes, settling after configuration, and sequencing of one emit.
`default_nettype none

module nfqs_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    input  wire logic                   item_kind,
    output logic                        item_ready,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output nfqs_pkg::nfqs_cmd_t         cmd,
    input  wire nfqs_pkg::nfqs_status_t status
);

    typedef enum logic [2:0] {
        ST_SETTLE0,
        ST_SETTLE1,
        ST_SETTLE2,
        ST_IDLE,
        ST_ADDR0,
        ST_ADDR1,
        ST_READ,
        ST_RESULT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   item_fire;
    logic   cfg_fire;
    logic   result_fire;
    logic   is_emit;

    assign cfg_ready    = (state_reg == ST_IDLE) || (state_reg == ST_SETTLE0)
                          || (state_reg == ST_SETTLE1) || (state_reg == ST_SETTLE2);
    // An item is taken only when the result register is free or being emptied.
    assign item_ready   = (state_reg == ST_IDLE) && !cfg_valid
                          && (!out_valid_reg || result_ready);
    assign item_fire    = item_valid && item_ready;
    assign cfg_fire     = cfg_valid && cfg_ready;
    assign result_fire  = out_valid_reg && result_ready;
    assign is_emit      = (item_kind == nfqs_pkg::KIND_EMIT);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        cmd.cfg_write   = cfg_fire;
        cmd.load_write  = item_fire && !is_emit && !status.size_error;
        cmd.emit_start  = item_fire && is_emit && !status.size_error;
        cmd.error_load  = item_fire && is_emit && status.size_error;
        cmd.result_load = (state_reg == ST_RESULT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SETTLE0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_SETTLE0: state_reg <= cfg_fire ? ST_SETTLE0 : ST_SETTLE1;
                ST_SETTLE1: state_reg <= cfg_fire ? ST_SETTLE0 : ST_SETTLE2;
                ST_SETTLE2: state_reg <= cfg_fire ? ST_SETTLE0 : ST_IDLE;
                ST_IDLE:
                begin
                    if (cfg_fire)
                        state_reg <= ST_SETTLE0;
                    else if (cmd.emit_start)
                        state_reg <= ST_ADDR0;
                end
                ST_ADDR0:  state_reg <= ST_ADDR1;
                ST_ADDR1:  state_reg <= ST_READ;
                ST_READ:   state_reg <= ST_RESULT;
                ST_RESULT: state_reg <= ST_IDLE;
            endcase

            if (cmd.error_load || cmd.result_load)
                out_valid_reg <= 1'b1;
            else if (result_fire)
                out_valid_reg <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_emit_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_start |-> ##5 out_valid_reg)
        else $error("emit did not produce a result after the address and read steps");

    a_error_immediate: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.error_load |=> out_valid_reg)
        else $error("size error emit did not produce a result");

    a_cfg_settles: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> !item_ready)
        else $error("item accepted before the frame size settled");
`endif

endmodule

`default_nettype wire

[rtl/core/nd_fft_quadrant_swap_core.sv]
// Top level of the multi-dimensional fftshift reorder core.
`default_nettype none

// Loads write one complex sample per beat into the store at the next linear position and
// leave the controller idle. An emit beat returns the sample for the next fftshifted output
// position; it occupies the core for two multiply steps that form the linear source
// address, one registered store read and the load of the result register, after which
// its result is valid. No beat of either kind is taken while a result waits on the output,
// unless that result is being accepted in the same cycle. When the frame size exceeds the
// store depth, an emit answers on the next cycle with a zeroed result flagged size_error
// and a load is dropped. After reset and after every configuration beat, the core takes
// no items while the controller steps through ST_SETTLE0 to ST_SETTLE2 and the frame size
// product is recomputed; configuration beats are taken during that time. The store is
// not cleared: reading a position that was never loaded gives an undefined sample.
module nd_fft_quadrant_swap_core #(
    parameter int STORE_DEPTH  = nfqs_pkg::STORE_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = nfqs_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    nfqs_item_if.sink     item,
    nfqs_result_if.source result,
    nfqs_cfg_if.sink      cfg
);

    nfqs_pkg::nfqs_cmd_t    cmd;
    nfqs_pkg::nfqs_status_t status;

    nfqs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_kind    (item.kind),
        .item_ready   (item.ready),
        .cfg_valid    (cfg.valid),
        .cfg_ready    (cfg.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd),
        .status       (status)
    );

    nfqs_datapath #(
        .STORE_DEPTH  (STORE_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .in_real    (item.in_real),
        .in_imag    (item.in_imag),
        .out_real   (result.out_real),
        .out_imag   (result.out_imag),
        .frame_last (result.frame_last),
        .size_error (result.size_error)
    );

endmodule

`default_nettype wire
